/* hw/rtl/m4vt_pkg.sv */
// ----------------------------------------------------------------------------
// m4vt_pkg: shared types and constants for the 4x4 matrix-vector transform
// Request payloads, pipeline control group and matrix reset values.
// ----------------------------------------------------------------------------
package m4vt_pkg;

    localparam int unsigned COMP_W       = 32;
    localparam int unsigned CFG_W        = 64;
    localparam int unsigned NUM_CFG      = 8;
    localparam int unsigned CFG_IDX_W    = $clog2(NUM_CFG);
    localparam int unsigned FRAC_BITS_DEF = 16;

    // full products and the two adder levels of one row
    localparam int unsigned PROD_W = 2 * COMP_W;
    localparam int unsigned PAIR_W = PROD_W + 1;
    localparam int unsigned SUM_W  = PROD_W + 2;

    localparam logic [COMP_W-1:0] SAT_POS = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic [COMP_W-1:0] SAT_NEG = {1'b1, {(COMP_W-1){1'b0}}};

    // default matrix in Q16.16, two entries per register
    // rows 1..3 pick y, z, w at 1.0; row 0 has only a one-lsb column 1 entry
    localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
        64'h0000_0001_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    typedef struct packed {
        logic signed [COMP_W-1:0] vec_x;
        logic signed [COMP_W-1:0] vec_y;
        logic signed [COMP_W-1:0] vec_z;
        logic signed [COMP_W-1:0] vec_w;
    } vec_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic signed [COMP_W-1:0] out_w;
        logic                     saturated;
    } res_t;

    // per-stage load enables, driven by the valid/ready chain of the top level
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

endpackage

/* hw/rtl/matrix4_vector_transform.sv */
// ----------------------------------------------------------------------------
// matrix4_vector_transform: 4x4 Q16.16 matrix times 4-vector
// Top level with matrix registers, valid/ready pipeline control and rows.
// ----------------------------------------------------------------------------
// Usage:
//   The matrix is loaded through cfg_we/cfg_idx/cfg_wdata, two Q16.16 entries
//   per 64-bit register (column 0/2 in the low half), while no request is in
//   flight. Vectors enter on s_valid/s_ready, results leave on
//   m_valid/m_ready, each component being the saturated Q16.16 dot product
//   of one matrix row with the vector; saturated flags any clamped component.
//   The stages from input accept to m_valid: products, pair sums, row sum,
//   shift and saturate into the output register. Throughput is one vector per
//   cycle unless m_ready stalls; the sixteen parallel 32x32 multipliers set
//   the first stage. Each stage has its own valid bit and loads when it is
//   empty or the stage after it moves, so a stalled m_ready fills the pipeline
//   (up to four requests) before s_ready drops, and bubbles are squeezed out.
//   Reset clears all valid bits and loads the default matrix: rows 1 to 3 pass
//   y, z and w through, row 0 weights y by a single lsb.
// ----------------------------------------------------------------------------
module matrix4_vector_transform #(
    parameter int unsigned FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [m4vt_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [m4vt_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  m4vt_pkg::vec_t                    s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output m4vt_pkg::res_t                    m_data
);
    import m4vt_pkg::*;

    logic [CFG_W-1:0] cfg_reg [NUM_CFG];

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    pipe_en_t en;

    logic signed [COMP_W-1:0] row_res   [4];
    logic                     row_clamp [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            cfg_reg[cfg_idx] <= cfg_wdata;
        end
    end

    // a stage may load when empty or when its contents move on
    assign rdy4 = !v4_reg || m_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign en.s1 = s_valid && rdy1;
    assign en.s2 = v1_reg && rdy2;
    assign en.s3 = v2_reg && rdy3;
    assign en.s4 = v3_reg && rdy4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    for (genvar r = 0; r < 4; r++) begin : g_row
        m4vt_row_dot #(
            .FRAC_BITS(FRAC_BITS)
        ) u_row (
            .aclk   (aclk),
            .en     (en),
            .row_lo (cfg_reg[2*r]),
            .row_hi (cfg_reg[2*r+1]),
            .vec    (s_data),
            .res    (row_res[r]),
            .clamp  (row_clamp[r])
        );
    end

    assign s_ready          = rdy1;
    assign m_valid          = v4_reg;
    assign m_data.out_x     = row_res[0];
    assign m_data.out_y     = row_res[1];
    assign m_data.out_z     = row_res[2];
    assign m_data.out_w     = row_res[3];
    assign m_data.saturated = row_clamp[0] || row_clamp[1] || row_clamp[2] || row_clamp[3];

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted request lost at first stage");

    a_last_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && rdy4) |=> m_valid)
        else $error("request lost entering output register");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.saturated) |->
            (m_data.out_x == SAT_POS || m_data.out_x == SAT_NEG ||
             m_data.out_y == SAT_POS || m_data.out_y == SAT_NEG ||
             m_data.out_z == SAT_POS || m_data.out_z == SAT_NEG ||
             m_data.out_w == SAT_POS || m_data.out_w == SAT_NEG))
        else $error("saturated flag without a clamped component");

endmodule

/* hw/rtl/m4vt_row_dot.sv */
// ----------------------------------------------------------------------------
// m4vt_row_dot: pipelined dot product of one matrix row with the vector
// Products, pair sums, row sum, then fixed-point shift and saturation.
// ----------------------------------------------------------------------------
module m4vt_row_dot #(
    parameter int unsigned FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  m4vt_pkg::pipe_en_t                    en,
    input  logic [m4vt_pkg::CFG_W-1:0]            row_lo,
    input  logic [m4vt_pkg::CFG_W-1:0]            row_hi,
    input  m4vt_pkg::vec_t                        vec,
    output logic signed [m4vt_pkg::COMP_W-1:0]    res,
    output logic                                  clamp
);
    import m4vt_pkg::*;

    logic signed [COMP_W-1:0] mat_e [4];
    logic signed [COMP_W-1:0] vec_e [4];

    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [COMP_W-1:0] res_reg;
    logic                     clamp_reg;

    logic signed [SUM_W-1:0]  shifted;
    logic [SUM_W-COMP_W:0]    top_bits;
    logic                     fits;

    assign mat_e[0] = row_lo[COMP_W-1:0];
    assign mat_e[1] = row_lo[CFG_W-1:COMP_W];
    assign mat_e[2] = row_hi[COMP_W-1:0];
    assign mat_e[3] = row_hi[CFG_W-1:COMP_W];

    assign vec_e[0] = vec.vec_x;
    assign vec_e[1] = vec.vec_y;
    assign vec_e[2] = vec.vec_z;
    assign vec_e[3] = vec.vec_w;

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            for (int c = 0; c < 4; c++) begin
                prod_reg[c] <= mat_e[c] * vec_e[c];
            end
        end
        if (en.s2) begin
            pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        end
        if (en.s3) begin
            sum_reg <= SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        end
        if (en.s4) begin
            res_reg   <= fits ? shifted[COMP_W-1:0]
                              : (shifted[SUM_W-1] ? SAT_NEG : SAT_POS);
            clamp_reg <= !fits;
        end
    end

    // floor shift, then in range when everything above bit 30 agrees
    assign shifted  = sum_reg >>> FRAC_BITS;
    assign top_bits = shifted[SUM_W-1:COMP_W-1];
    assign fits     = (&top_bits) || !(|top_bits);

    assign res   = res_reg;
    assign clamp = clamp_reg;

endmodule

/* tb/tb_matrix4_vector_transform.sv */
// ----------------------------------------------------------------------------
// tb_matrix4_vector_transform: self-checking bench for the 4x4 transform
// Loads a series of matrices, streams vectors with random gaps and output
// stalls, and compares every result against a local Q16.16 predictor.
// ----------------------------------------------------------------------------
module tb_matrix4_vector_transform;

    timeunit 1ns;
    timeprecision 1ps;

    import m4vt_pkg::*;

    localparam int unsigned FRAC     = FRAC_BITS_DEF;
    localparam int unsigned WD_LIMIT = 2000;
    localparam int unsigned SETTLE   = 8;

    localparam logic signed [65:0] ROW_MAX = 66'sd2147483647;
    localparam logic signed [65:0] ROW_MIN = -66'sd2147483648;

    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_NEG1 = 32'hFFFF_FFFF;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    vec_t                 s_data;
    logic                 m_valid;
    logic                 m_ready;
    res_t                 m_data;

    // local copy of the matrix registers
    logic [CFG_W-1:0] matrix_regs [NUM_CFG];
    res_t             pending_results [$];
    int               fails;
    int unsigned      quiet_cycles;
    bit               tx_gaps;
    bit               rx_stalls;

    matrix4_vector_transform uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic res_t transform_vector(vec_t v);
        res_t              r;
        logic signed [65:0] comp [4];
        logic signed [65:0] acc;
        logic signed [65:0] ent;
        logic signed [65:0] shifted;
        logic signed [31:0] e32;
        logic [31:0]        row_out [4];
        logic [CFG_W-1:0]   reg_val;
        int                 row;
        int                 col;
        r = '0;
        comp[0] = $signed(v.vec_x);
        comp[1] = $signed(v.vec_y);
        comp[2] = $signed(v.vec_z);
        comp[3] = $signed(v.vec_w);
        for (row = 0; row < 4; row++) begin
            acc = '0;
            for (col = 0; col < 4; col++) begin
                reg_val = matrix_regs[2 * row + col / 2];
                e32 = (col % 2 == 1) ? reg_val[63:32] : reg_val[31:0];
                ent = e32;
                acc = acc + ent * comp[col];
            end
            // arithmetic shift floors negative sums
            shifted = acc >>> FRAC;
            if (shifted > ROW_MAX) begin
                row_out[row] = SAT_POS;
                r.saturated = 1'b1;
            end else if (shifted < ROW_MIN) begin
                row_out[row] = SAT_NEG;
                r.saturated = 1'b1;
            end else begin
                row_out[row] = shifted[31:0];
            end
        end
        r.out_x = row_out[0];
        r.out_y = row_out[1];
        r.out_z = row_out[2];
        r.out_w = row_out[3];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checking and watchdog
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %h", m_data);
                fails++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_x", want.out_x, m_data.out_x);
                check_field("out_y", want.out_y, m_data.out_y);
                check_field("out_z", want.out_z, m_data.out_z);
                check_field("out_w", want.out_w, m_data.out_w);
                check_field("saturated", {31'b0, want.saturated}, {31'b0, m_data.saturated});
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WD_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output side: random stall before each result when rx_stalls is set
    initial begin
        int stall;
        forever begin
            stall = rx_stalls ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers, entered and left just after a falling edge
    // ------------------------------------------------------------------------
    task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [31:0] w);
        vec_t v;
        int   gap;
        v   = {x, y, z, w};
        gap = tx_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = v;
        pending_results.push_back(transform_vector(v));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold off new requests until every result is back
    task automatic drain_pipeline();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_cfg(input int idx, input logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_idx   = idx[CFG_IDX_W-1:0];
        cfg_wdata = value;
        matrix_regs[idx] = value;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic fill_matrix(input logic [31:0] entry);
        drain_pipeline();
        for (int i = 0; i < NUM_CFG; i++) write_cfg(i, {entry, entry});
    endtask

    function automatic logic [31:0] rand_entry(input int mode);
        logic [31:0] e;
        int          pick;
        pick = (mode == 2) ? $urandom_range(0, 2) : mode;
        case (pick)
            0: e = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            1: e = $urandom;
            default: begin
                case ($urandom_range(0, 5))
                    0: e = '0;
                    1: e = Q_ONE;
                    2: e = -Q_ONE;
                    3: e = Q_MAX;
                    4: e = Q_MIN;
                    default: e = Q_NEG1;
                endcase
            end
        endcase
        return e;
    endfunction

    function automatic logic [31:0] rand_comp();
        logic [31:0] c;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: c = $urandom;
            4, 5: c = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            6: c = rand_entry(3);
            default: c = Q_ONE * ($urandom_range(0, 64) - 32);
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_identity_matrix();
        // matrix after reset: y, z, w pass through, x gets y at one-lsb weight
        send_vector('0, '0, '0, '0);
        send_vector(Q_MAX, Q_MIN, Q_NEG1, 32'h1);
        send_vector(Q_MIN, Q_MAX, 32'h1, Q_NEG1);
        send_vector(Q_ONE, 32'hFFFF_0000, 32'h7FFF_0000, 32'h8000_FFFF);
    endtask

    task automatic test_saturation_limits();
        fill_matrix(Q_MAX);
        send_vector(Q_ONE, '0, '0, '0);
        send_vector(Q_ONE, Q_ONE, '0, '0);
        send_vector(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_vector(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        fill_matrix(Q_MIN);
        send_vector(Q_ONE, '0, '0, '0);
        send_vector(Q_ONE, 32'h1, '0, '0);
        send_vector(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        // mixed signs: one row up, the next down
        drain_pipeline();
        write_cfg(0, {Q_MAX, Q_MAX});
        write_cfg(2, {Q_MIN, Q_MIN});
        write_cfg(4, {Q_ONE, '0});
        write_cfg(6, {32'h1, Q_NEG1});
        send_vector(Q_MAX, Q_MAX, Q_MIN, Q_MAX);
        send_vector(Q_NEG1, 32'h1, Q_ONE, Q_MIN);
    endtask

    task automatic test_uniform_matrices();
        // all ones: every entry is the smallest negative step, sums floor
        fill_matrix(Q_NEG1);
        send_vector(32'h1, 32'h1, 32'h1, 32'h1);
        send_vector(Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1);
        send_vector(Q_MAX, 32'h1234_5678, Q_MIN, 32'h8765_4321);
        fill_matrix('0);
        send_vector(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    endtask

    task automatic test_random_transforms(input int phases, input int per_phase);
        logic [31:0] lo;
        logic [31:0] hi;
        int          mode;
        for (int p = 0; p < phases; p++) begin
            drain_pipeline();
            mode = p % 3;
            for (int i = 0; i < NUM_CFG; i++) begin
                lo = rand_entry(mode);
                hi = rand_entry(mode);
                write_cfg(i, {hi, lo});
            end
            case (p % 4)
                0: begin tx_gaps = 1'b1; rx_stalls = 1'b1; end
                1: begin tx_gaps = 1'b0; rx_stalls = 1'b0; end
                2: begin tx_gaps = 1'b0; rx_stalls = 1'b1; end
                default: begin tx_gaps = 1'b1; rx_stalls = 1'b0; end
            endcase
            for (int n = 0; n < per_phase; n++) begin
                send_vector(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            end
        end
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    initial begin
        fails        = 0;
        quiet_cycles = 0;
        tx_gaps      = 1'b1;
        rx_stalls    = 1'b1;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        for (int i = 0; i < NUM_CFG; i++) matrix_regs[i] = CFG_RESET[i];
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(negedge aclk);

        test_identity_matrix();
        test_saturation_limits();
        test_uniform_matrices();
        test_random_transforms(6, 122);

        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fails++;
        end
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* matrix4_vector_transform.f */
hw/rtl/m4vt_pkg.sv
hw/rtl/m4vt_row_dot.sv
hw/rtl/matrix4_vector_transform.sv
tb/tb_matrix4_vector_transform.sv
